/* rtl/core/gssr_pkg.sv */
package gssr_pkg;

  localparam int unsigned DefMaxGenBlocks   = 8;
  localparam int unsigned DefMaxRowsPerBlk  = 64;
  localparam int unsigned DefVecBits        = 128;
  localparam int unsigned DefMaxCoordBlocks = 8;

  localparam int unsigned RankW = 8;
  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    REG_COORD_BLOCKS = 2'd0,
    REG_BLOCK_WIDTH  = 2'd1,
    REG_GEN_BLOCKS   = 2'd2
  } reg_idx_e;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UNIT  = 5'b00010,
    ST_GEN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } feed_state_e;

  // token control traveling with a row through the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

  typedef struct packed {
    logic busy;
    logic done;
  } feed_stat_t;

  typedef struct packed {
    logic [3:0] coord_blocks;
    logic [7:0] block_width;
    logic [3:0] gen_blocks;
  } cfg_t;

endpackage

/* rtl/core/gf2_subset_span_rank_top.sv */
// Row write: accepted without a result; the input stays ready for the next word.
// Rank query: the feed steps through each unit-row position (also past VEC_BITS), each
// skipped coordinate block, each stored row fed and each generator block below gen_blocks,
// then checks the block limits and drains the chain before the rank word is handed off.
// Queries: one at a time; the input is not ready while the feed sequencer is busy.
// Reset: asynchronous, active low; config returns to 1/1/0, block row counts clear,
// cell pivots clear; stored rows stay undefined until written.
module gf2_subset_span_rank_top #(
  parameter int unsigned MAX_GEN_BLOCKS     = gssr_pkg::DefMaxGenBlocks,
  parameter int unsigned MAX_ROWS_PER_BLOCK = gssr_pkg::DefMaxRowsPerBlk,
  parameter int unsigned VEC_BITS           = gssr_pkg::DefVecBits,
  parameter int unsigned MAX_COORD_BLOCKS   = gssr_pkg::DefMaxCoordBlocks
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // gen_block[2:0], row_index[8:3], rows_in_block[15:9], vec_high[79:16],
  // vec_low[143:80], subset[159:144]
  input  logic [159:0]               s_axis_tdata,
  // func[0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // rank[7:0]
  output logic [7:0]                 m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gssr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  gssr_pkg::cfg_t       cfg_q;
  gssr_pkg::feed_stat_t stat;
  gssr_pkg::tok_t       feed_tok, chain_tok;
  logic [VEC_BITS-1:0]  feed_vec;
  logic [127:0]         wr_vec_full;
  logic                 in_acc, start, wr, ack;
  logic [gssr_pkg::RankW-1:0] rank_q, out_q;
  logic                 out_vld_q;
  gssr_pkg::reg_idx_e   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = gssr_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coord_blocks <= 4'd1;
      cfg_q.block_width  <= 8'd1;
      cfg_q.gen_blocks   <= 4'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        gssr_pkg::REG_COORD_BLOCKS: cfg_q.coord_blocks <= pwdata[3:0];
        gssr_pkg::REG_BLOCK_WIDTH:  cfg_q.block_width  <= pwdata[7:0];
        gssr_pkg::REG_GEN_BLOCKS:   cfg_q.gen_blocks   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gssr_pkg::REG_COORD_BLOCKS: prdata = {28'd0, cfg_q.coord_blocks};
      gssr_pkg::REG_BLOCK_WIDTH:  prdata = {24'd0, cfg_q.block_width};
      gssr_pkg::REG_GEN_BLOCKS:   prdata = {28'd0, cfg_q.gen_blocks};
      default:                    prdata = '0;
    endcase
  end

  assign s_axis_tready = !stat.busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign start         = in_acc && (s_axis_tuser == gssr_pkg::FUNC_QUERY);
  assign wr            = in_acc && (s_axis_tuser == gssr_pkg::FUNC_WRITE);
  assign ack           = stat.done && (!out_vld_q || m_axis_tready);
  assign wr_vec_full   = {s_axis_tdata[79:16], s_axis_tdata[143:80]};

  gssr_feed #(
    .MAX_GEN_BLOCKS    (MAX_GEN_BLOCKS),
    .MAX_ROWS_PER_BLOCK(MAX_ROWS_PER_BLOCK),
    .VEC_BITS          (VEC_BITS),
    .MAX_COORD_BLOCKS  (MAX_COORD_BLOCKS)
  ) u_feed (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (start),
    .subset_i  (s_axis_tdata[159:144]),
    .wr_i      (wr),
    .wr_block_i(s_axis_tdata[2:0]),
    .wr_row_i  (s_axis_tdata[8:3]),
    .wr_count_i(s_axis_tdata[15:9]),
    .wr_vec_i  (wr_vec_full[VEC_BITS-1:0]),
    .ack_i     (ack),
    .stat_o    (stat),
    .tok_o     (feed_tok),
    .vec_o     (feed_vec)
  );

  gssr_chain #(
    .VEC_BITS(VEC_BITS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(start),
    .tok_i  (feed_tok),
    .vec_i  (feed_vec),
    .tok_o  (chain_tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (start) begin
        rank_q <= '0;
      end else if (chain_tok.valid && chain_tok.hit) begin
        rank_q <= rank_q + gssr_pkg::RankW'(1);
      end
      if (ack) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= rank_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= gssr_pkg::RankW'(VEC_BITS)))
    else $error("rank beyond vector width");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> stat.busy)
    else $error("query accepted but feed idle");

  a_no_hit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_tok.valid && chain_tok.hit) |-> stat.busy)
    else $error("pivot taken outside a query");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.done && out_vld_q && !m_axis_tready) |=> stat.done)
    else $error("result dropped while output full");

endmodule

/* rtl/core/gssr_cell.sv */
module gssr_cell #(
  parameter int unsigned VEC_BITS = gssr_pkg::DefVecBits,
  parameter int unsigned POS      = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  gssr_pkg::tok_t      tok_i,
  input  logic [VEC_BITS-1:0] vec_i,
  output gssr_pkg::tok_t      tok_o,
  output logic [VEC_BITS-1:0] vec_o
);

  logic                occ_q, occ_d;
  logic [VEC_BITS-1:0] row_q, row_d;
  gssr_pkg::tok_t      tok_q, tok_d;
  logic [VEC_BITS-1:0] vec_q, vec_d;

  always_comb begin
    occ_d = occ_q;
    row_d = row_q;
    tok_d = tok_i;
    vec_d = vec_i;
    if (tok_i.valid && vec_i[POS]) begin
      if (occ_q) begin
        vec_d = vec_i ^ row_q;
      end else begin
        // take the word as this pivot's row
        occ_d     = 1'b1;
        row_d     = vec_i;
        vec_d     = '0;
        tok_d.hit = 1'b1;
      end
    end
    if (clear_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    vec_q <= vec_d;
  end

  assign tok_o = tok_q;
  assign vec_o = vec_q;

endmodule

/* rtl/core/gssr_chain.sv */
module gssr_chain #(
  parameter int unsigned VEC_BITS = gssr_pkg::DefVecBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  gssr_pkg::tok_t      tok_i,
  input  logic [VEC_BITS-1:0] vec_i,
  output gssr_pkg::tok_t      tok_o
);

  gssr_pkg::tok_t      tok_w [VEC_BITS+1];
  logic [VEC_BITS-1:0] vec_w [VEC_BITS+1];

  assign tok_w[0] = tok_i;
  assign vec_w[0] = vec_i;

  // cell c owns pivot bit VEC_BITS-1-c, highest bit first
  for (genvar c = 0; c < VEC_BITS; c++) begin : g_cell
    gssr_cell #(
      .VEC_BITS(VEC_BITS),
      .POS     (VEC_BITS - 1 - c)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clear_i(clear_i),
      .tok_i  (tok_w[c]),
      .vec_i  (vec_w[c]),
      .tok_o  (tok_w[c+1]),
      .vec_o  (vec_w[c+1])
    );
  end

  assign tok_o = tok_w[VEC_BITS];

endmodule

/* rtl/core/gssr_feed.sv */
module gssr_feed #(
  parameter int unsigned MAX_GEN_BLOCKS     = gssr_pkg::DefMaxGenBlocks,
  parameter int unsigned MAX_ROWS_PER_BLOCK = gssr_pkg::DefMaxRowsPerBlk,
  parameter int unsigned VEC_BITS           = gssr_pkg::DefVecBits,
  parameter int unsigned MAX_COORD_BLOCKS   = gssr_pkg::DefMaxCoordBlocks
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gssr_pkg::cfg_t       cfg_i,
  input  logic                 start_i,
  input  logic [15:0]          subset_i,
  input  logic                 wr_i,
  input  logic [2:0]           wr_block_i,
  input  logic [5:0]           wr_row_i,
  input  logic [6:0]           wr_count_i,
  input  logic [VEC_BITS-1:0]  wr_vec_i,
  input  logic                 ack_i,
  output gssr_pkg::feed_stat_t stat_o,
  output gssr_pkg::tok_t       tok_o,
  output logic [VEC_BITS-1:0]  vec_o
);

  localparam int unsigned Depth  = MAX_GEN_BLOCKS * MAX_ROWS_PER_BLOCK;
  localparam int unsigned AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned GW     = (MAX_GEN_BLOCKS > 1) ? $clog2(MAX_GEN_BLOCKS) : 1;
  localparam int unsigned PW     = (VEC_BITS > 1) ? $clog2(VEC_BITS) : 1;
  localparam int unsigned DrainN = VEC_BITS + 4;
  localparam int unsigned DW     = $clog2(DrainN + 1);

  logic [VEC_BITS-1:0] mem_q [Depth];
  logic [6:0]          rows_q [MAX_GEN_BLOCKS];

  gssr_pkg::feed_state_e state_q, state_d;
  logic [15:0]   subset_q;
  logic [3:0]    g_q, g_d;
  logic [7:0]    i_q, i_d;
  logic [11:0]   pos_q, pos_d;
  logic [3:0]    j_q, j_d;
  logic [6:0]    k_q, k_d;
  logic [DW-1:0] drain_q, drain_d;

  logic [3:0]    m_lim, r_lim;
  logic [4:0]    sel_idx;
  logic [6:0]    n_rows;
  logic          emit_unit, rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_ok;

  logic                unit_vld_q, rd_vld_q;
  logic [VEC_BITS-1:0] unit_vec_q, rd_data_q;

  assign m_lim = (cfg_i.coord_blocks > 4'(MAX_COORD_BLOCKS)) ? 4'(MAX_COORD_BLOCKS)
                                                             : cfg_i.coord_blocks;
  assign r_lim = (cfg_i.gen_blocks > 4'(MAX_GEN_BLOCKS)) ? 4'(MAX_GEN_BLOCKS)
                                                         : cfg_i.gen_blocks;
  assign sel_idx = {1'b0, m_lim} + {1'b0, j_q};
  assign n_rows  = rows_q[j_q[GW-1:0]];
  assign rd_addr = AW'(int'(j_q) * MAX_ROWS_PER_BLOCK + int'(k_q));
  assign wr_addr = AW'(int'(wr_block_i) * MAX_ROWS_PER_BLOCK + int'(wr_row_i));
  assign wr_ok   = wr_i && (int'(wr_block_i) < MAX_GEN_BLOCKS);

  always_comb begin
    state_d   = state_q;
    g_d       = g_q;
    i_d       = i_q;
    pos_d     = pos_q;
    j_d       = j_q;
    k_d       = k_q;
    drain_d   = drain_q;
    emit_unit = 1'b0;
    rd_en     = 1'b0;
    case (state_q)
      gssr_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = gssr_pkg::ST_UNIT;
          g_d     = '0;
          i_d     = '0;
          pos_d   = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      gssr_pkg::ST_UNIT: begin
        if (g_q >= m_lim) begin
          state_d = gssr_pkg::ST_GEN;
        end else if (!subset_q[g_q] || (cfg_i.block_width == 8'd0)) begin
          pos_d = pos_q + 12'(cfg_i.block_width);
          g_d   = g_q + 4'd1;
          i_d   = '0;
        end else begin
          emit_unit = 1'b1;
          pos_d     = pos_q + 12'd1;
          if (i_q == cfg_i.block_width - 8'd1) begin
            g_d = g_q + 4'd1;
            i_d = '0;
          end else begin
            i_d = i_q + 8'd1;
          end
        end
      end
      gssr_pkg::ST_GEN: begin
        if (j_q >= r_lim) begin
          state_d = gssr_pkg::ST_DRAIN;
          drain_d = '0;
        end else if (!subset_q[sel_idx[3:0]] || (k_q >= n_rows)) begin
          j_d = j_q + 4'd1;
          k_d = '0;
        end else begin
          rd_en = 1'b1;
          k_d   = k_q + 7'd1;
        end
      end
      gssr_pkg::ST_DRAIN: begin
        // let the last words leave the chain
        if (drain_q == DW'(DrainN)) begin
          state_d = gssr_pkg::ST_DONE;
        end else begin
          drain_d = drain_q + DW'(1);
        end
      end
      gssr_pkg::ST_DONE: begin
        if (ack_i) begin
          state_d = gssr_pkg::ST_IDLE;
        end
      end
      default: state_d = gssr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gssr_pkg::ST_IDLE;
      unit_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      for (int b = 0; b < MAX_GEN_BLOCKS; b++) begin
        rows_q[b] <= '0;
      end
    end else begin
      state_q    <= state_d;
      unit_vld_q <= emit_unit && (pos_q < 12'(VEC_BITS));
      rd_vld_q   <= rd_en;
      if (wr_ok) begin
        rows_q[wr_block_i[GW-1:0]] <= (wr_count_i > 7'(MAX_ROWS_PER_BLOCK))
                                      ? 7'(MAX_ROWS_PER_BLOCK) : wr_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    g_q     <= g_d;
    i_q     <= i_d;
    pos_q   <= pos_d;
    j_q     <= j_d;
    k_q     <= k_d;
    drain_q <= drain_d;
    if (start_i) begin
      subset_q <= subset_i;
    end
    unit_vec_q <= VEC_BITS'(1) << pos_q[PW-1:0];
    if (wr_ok && (int'(wr_row_i) < MAX_ROWS_PER_BLOCK)) begin
      mem_q[wr_addr] <= wr_vec_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign tok_o.valid = unit_vld_q | rd_vld_q;
  assign tok_o.hit   = 1'b0;
  assign vec_o       = rd_vld_q ? rd_data_q : unit_vec_q;
  assign stat_o.busy = (state_q != gssr_pkg::ST_IDLE);
  assign stat_o.done = (state_q == gssr_pkg::ST_DONE);

endmodule
